[hw/rtl/mas_pkg.sv]
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package mas_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = 3;                 // row and column index width
  localparam int DIM_W      = 4;                 // size register width, holds MAX_DIM
  localparam int ADDR_W     = 2 * IDX_W;         // row-major store address
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int OP_W       = 2;
  localparam int ACT_W      = 2;
  localparam int S_TDATA_W  = 40;                // row, col, value, zero pad
  localparam int M_TDATA_W  = 40;                // value, row, col, zero pad

  // input item kinds
  localparam logic [ACT_W-1:0] ACT_WR_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OP     = 3'd4;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              first;      // first term of a result element
    logic              lastk;      // final term of a result element
    logic [OP_W-1:0]   op;
    logic              push;       // load the output register
    logic              push_err;
    logic              push_last;
    logic [IDX_W-1:0]  push_row;
    logic [IDX_W-1:0]  push_col;
  } mas_cmd_t;

  typedef struct packed {
    logic done;       // accumulator holds a finished element
    logic out_free;   // output register can take an item this cycle
  } mas_sts_t;

endpackage

[hw/rtl/mas_dp.sv]
// datapath: matrix stores, arithmetic pipeline, accumulator and output register
`timescale 1ns / 1ps

module mas_dp import mas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  mas_cmd_t              cmd,
  output mas_sts_t              sts,
  input  logic [DATA_WIDTH-1:0] wr_value,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser
);

  logic [DATA_WIDTH-1:0] mem_a [DEPTH];
  logic [DATA_WIDTH-1:0] mem_b [DEPTH];

  logic [DATA_WIDTH-1:0] a_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic                  v1;
  logic                  first1;
  logic                  lastk1;
  logic [DATA_WIDTH-1:0] term;
  logic                  v2;
  logic                  first2;
  logic                  lastk2;
  logic [DATA_WIDTH-1:0] acc;
  logic                  done;
  logic [DATA_WIDTH-1:0] term_next;
  logic [DATA_WIDTH-1:0] result_value;
  logic [IDX_W-1:0]      result_row;
  logic [IDX_W-1:0]      result_col;

  // stores, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[cmd.wr_addr] <= wr_value;
    end
    if (cmd.wr_b) begin
      mem_b[cmd.wr_addr] <= wr_value;
    end
    if (cmd.rd_en) begin
      a_q <= mem_a[cmd.rd_addr_a];
      b_q <= mem_b[cmd.rd_addr_b];
    end
  end

  always_comb begin
    case (cmd.op)
      OP_ADD:  term_next = a_q + b_q;
      OP_SUB:  term_next = a_q - b_q;
      OP_MUL:  term_next = a_q * b_q;
      default: term_next = '0;
    endcase
  end

  // term and accumulator stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      done   <= 1'b0;
      first1 <= 1'b0;
      lastk1 <= 1'b0;
      first2 <= 1'b0;
      lastk2 <= 1'b0;
    end else begin
      v1     <= cmd.rd_en;
      first1 <= cmd.first;
      lastk1 <= cmd.lastk;
      v2     <= v1;
      first2 <= first1;
      lastk2 <= lastk1;
      if (cmd.push) begin
        done <= 1'b0;
      end else if (v2 && lastk2) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      term <= term_next;
    end
    if (v2) begin
      acc <= first2 ? term : acc + term;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result_value <= cmd.push_err ? '0 : acc;
      result_row   <= cmd.push_err ? '0 : cmd.push_row;
      result_col   <= cmd.push_err ? '0 : cmd.push_col;
      m_axis_tlast <= cmd.push_last;
      m_axis_tuser <= cmd.push_err;
    end
  end

  assign m_axis_tdata = {{(M_TDATA_W - DATA_WIDTH - 2 * IDX_W){1'b0}},
                         result_col, result_row, result_value};

  assign sts.done     = done;
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  a_done_after_last_term: assert property (@(posedge clk) disable iff (rst)
    v2 && lastk2 && !cmd.push |=> done)
    else $error("accumulator finished without done");

  a_push_ok_push_needs_done: assert property (@(posedge clk) disable iff (rst)
    cmd.push && !cmd.push_err |-> done)
    else $error("result pushed before accumulation finished");

  a_push_into_free_reg: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while held");

endmodule

[hw/rtl/mas_ctrl.sv]
// controller: size registers, item decode, run sequencing over rows, columns and terms
`timescale 1ns / 1ps

module mas_ctrl import mas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [IDX_W-1:0]      in_row,
  input  logic [IDX_W-1:0]      in_col,
  output mas_cmd_t              cmd,
  input  mas_sts_t              sts
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_ERR} state_t;

  state_t           state;
  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] cols_a;
  logic [DIM_W-1:0] rows_b;
  logic [DIM_W-1:0] cols_b;
  logic [OP_W-1:0]  op;

  logic [DIM_W-1:0] nr;
  logic [DIM_W-1:0] nc;
  logic [DIM_W-1:0] nk;
  logic [OP_W-1:0]  op_run;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;

  logic [DIM_W-1:0] ra;
  logic [DIM_W-1:0] ca;
  logic [DIM_W-1:0] rb;
  logic [DIM_W-1:0] cb;
  logic             mismatch;
  logic             accept;
  logic             k_last;
  logic             i_last;
  logic             j_last;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign ra = clamp_dim(rows_a);
  assign ca = clamp_dim(cols_a);
  assign rb = clamp_dim(rows_b);
  assign cb = clamp_dim(cols_b);

  always_comb begin
    case (op)
      OP_ADD, OP_SUB: mismatch = (ra != rb) || (ca != cb);
      OP_MUL:         mismatch = (ca != rb);
      default:        mismatch = 1'b1;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign k_last   = ({1'b0, k} == nk - DIM_W'(1));
  assign i_last   = ({1'b0, i} == nr - DIM_W'(1));
  assign j_last   = ({1'b0, j} == nc - DIM_W'(1));

  always_comb begin
    cmd           = '0;
    cmd.wr_a      = accept && (in_action == ACT_WR_A);
    cmd.wr_b      = accept && (in_action == ACT_WR_B);
    cmd.wr_addr   = {in_row, in_col};
    cmd.op        = op_run;
    cmd.push_row  = i;
    cmd.push_col  = j;
    cmd.first     = (k == '0);
    cmd.lastk     = k_last;
    if (op_run == OP_MUL) begin
      cmd.rd_addr_a = {i, k};
      cmd.rd_addr_b = {k, j};
    end else begin
      cmd.rd_addr_a = {i, j};
      cmd.rd_addr_b = {i, j};
    end
    case (state)
      S_ISSUE: cmd.rd_en = 1'b1;
      S_WAIT: begin
        cmd.push      = sts.done && sts.out_free;
        cmd.push_last = i_last && j_last;
      end
      S_ERR: begin
        cmd.push      = sts.out_free;
        cmd.push_err  = 1'b1;
        cmd.push_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rows_a <= DIM_W'(1);
      cols_a <= DIM_W'(1);
      rows_b <= DIM_W'(1);
      cols_b <= DIM_W'(1);
      op     <= OP_ADD;
      op_run <= OP_ADD;
      nr     <= DIM_W'(1);
      nc     <= DIM_W'(1);
      nk     <= DIM_W'(1);
      i      <= '0;
      j      <= '0;
      k      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A: rows_a <= cfg_data;
          REG_COLS_A: cols_a <= cfg_data;
          REG_ROWS_B: rows_b <= cfg_data;
          REG_COLS_B: cols_b <= cfg_data;
          REG_OP:     op     <= cfg_data[OP_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept && in_action == ACT_RUN) begin
            i      <= '0;
            j      <= '0;
            k      <= '0;
            op_run <= op;
            nr     <= ra;
            nc     <= (op == OP_MUL) ? cb : ca;
            nk     <= (op == OP_MUL) ? ca : DIM_W'(1);
            state  <= mismatch ? S_ERR : S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (k_last) begin
            k     <= '0;
            state <= S_WAIT;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (cmd.push) begin
            if (cmd.push_last) begin
              state <= S_IDLE;
            end else begin
              state <= S_ISSUE;
              if (j_last) begin
                j <= '0;
                i <= i + IDX_W'(1);
              end else begin
                j <= j + IDX_W'(1);
              end
            end
          end
        end
        S_ERR: begin
          if (cmd.push) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_push_ends_run: assert property (@(posedge clk) disable iff (rst)
    cmd.push && cmd.push_last |=> state == S_IDLE)
    else $error("run did not end after its last item");

  a_new_element_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en && cmd.first |-> !sts.done)
    else $error("element started while previous result unpushed");

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !in_ready)
    else $error("input taken during a run");

endmodule

[hw/rtl/matrix_add_sub_multiply_core.sv]
// top level: integer matrix add, subtract and multiply core
`timescale 1ns / 1ps

// channel   signals                         item contents
// --------  ------------------------------  ---------------------------------------------
// input     s_axis_tvalid/tready/tdata/tuser tdata: row, col, value; tuser: action
// output    m_axis_tvalid/tready/tdata/tlast tdata: value, row, col; tlast; tuser: status
//           m_axis_tuser
// config    cfg_we, cfg_index, cfg_data      size and operation registers, write only
//
// a write item is stored in the same cycle in which it is taken
// add or subtract: each result item passes read, term, accumulate and push in order;
// multiply: each result item sums cols_of_a terms, one multiply-accumulate term per cycle
// against the single read port of each store, and is pushed before the next item starts
// a size mismatch gives one error item after the run item
// rst is synchronous; stores hold no reset value; m_axis_tready low holds the run

module matrix_add_sub_multiply_core import mas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // row_index[2:0], col_index[5:3],
                                                // element_value[37:6], zero pad
  input  logic [ACT_W-1:0]      s_axis_tuser,   // action[1:0]
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // result_value[31:0], result_row[34:32],
                                                // result_col[37:35], zero pad
  output logic                  m_axis_tlast,   // last
  output logic                  m_axis_tuser    // status[0]
);

  mas_cmd_t cmd;
  mas_sts_t sts;

  // item field split
  logic [IDX_W-1:0]      in_row;
  logic [IDX_W-1:0]      in_col;
  logic [DATA_WIDTH-1:0] in_value;

  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_axis_tdata[2*IDX_W+DATA_WIDTH-1:2*IDX_W];

  // sequencing of loads and runs
  mas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_row    (in_row),
    .in_col    (in_col),
    .cmd       (cmd),
    .sts       (sts)
  );

  // stores, arithmetic and output register
  mas_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .wr_value      (in_value),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
